/* rtl/divider_and_reload_timer_top_assert.svh */
// Assertion macros shared by the divider and reload timer RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef DIVIDER_AND_RELOAD_TIMER_TOP_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DRT_ASSERT(lbl, prop, msg)
`define DRT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/drt_pkg.sv */
// Package for the divider and reload timer: constants, register map,
// configuration and result structs, timer period lookup. No dependencies.
package drt_pkg;

  localparam int DIV_PERIOD_DEF  = 256;
  localparam int MAX_ELAPSED_DEF = 24;

  localparam int CYC_W   = 5;   // elapsed_cycles width
  localparam int BYTE_W  = 8;
  localparam int TACC_W  = 11;  // timer accumulator width
  localparam int CSEL_W  = 2;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [BYTE_W-1:0] DIV_BYTE_RST = 8'hAB;

  typedef enum logic [1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_RELOAD_VALUE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              timer_enable;
    logic [CSEL_W-1:0] clock_select;
    logic [BYTE_W-1:0] reload_value;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] divider_value;
    logic [BYTE_W-1:0] counter_value;
    logic              overflow_irq;
  } res_t;

  // Timer period in cycles for each clock select code.
  function automatic logic [TACC_W-1:0] period_of(input logic [CSEL_W-1:0] sel);
    logic [TACC_W-1:0] p;
    case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      2'd3:    p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

/* rtl/drt_cfg.sv */
// APB-style register file for the divider and reload timer.
// Depends on drt_pkg for the register map and cfg_t.
module drt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drt_pkg::APB_AW-1:0]  paddr,
  input  logic [drt_pkg::APB_DW-1:0]  pwdata,
  output logic [drt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output drt_pkg::cfg_t               cfg
);
  import drt_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TIMER_ENABLE: cfg_nxt.timer_enable = pwdata[0];
        REG_CLOCK_SELECT: cfg_nxt.clock_select = pwdata[CSEL_W-1:0];
        REG_RELOAD_VALUE: cfg_nxt.reload_value = pwdata[BYTE_W-1:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_TIMER_ENABLE: prdata[0] = cfg_r.timer_enable;
      REG_CLOCK_SELECT: prdata[CSEL_W-1:0] = cfg_r.clock_select;
      REG_RELOAD_VALUE: prdata[BYTE_W-1:0] = cfg_r.reload_value;
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/drt_core.sv */
// Divider and timer state with the per-beat update logic.
// Depends on drt_pkg; the top level registers its result.
`include "divider_and_reload_timer_top_assert.svh"

module drt_core #(
  parameter int DIV_PERIOD  = drt_pkg::DIV_PERIOD_DEF,
  parameter int MAX_ELAPSED = drt_pkg::MAX_ELAPSED_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [drt_pkg::CYC_W-1:0]  cycles,
  input  drt_pkg::cfg_t              cfg,
  output drt_pkg::res_t              res
);
  import drt_pkg::*;

  localparam int DACC_W = $clog2(DIV_PERIOD + MAX_ELAPSED);
  localparam logic [DACC_W-1:0] DPER = DACC_W'(DIV_PERIOD);
  localparam int TSUM_W = TACC_W + 1;

  logic [DACC_W-1:0] dacc_r, dacc_nxt, dsum, d1, d2;
  logic [BYTE_W-1:0] dbyte_r, dbyte_nxt, db1, db2;
  logic [TACC_W-1:0] tacc_r, tacc_nxt;
  logic [TSUM_W-1:0] tsum, t1, t2, tper;
  logic [BYTE_W-1:0] tbyte_r, tbyte_nxt, tb1, tb2;
  logic              irq_nxt;

  // Divider: at most two periods drained per beat.
  always_comb begin
    dsum = dacc_r + DACC_W'(cycles);
    d1   = dsum;
    db1  = dbyte_r;
    if (dsum >= DPER) begin
      d1  = dsum - DPER;
      db1 = dbyte_r + 8'd1;
    end
    d2  = d1;
    db2 = db1;
    if (d1 >= DPER) begin
      d2  = d1 - DPER;
      db2 = db1 + 8'd1;
    end
    dacc_nxt  = step_en ? d2 : dacc_r;
    dbyte_nxt = step_en ? db2 : dbyte_r;
  end

  // Timer: two passes, each may wrap and reload the counter.
  always_comb begin
    tper    = {1'b0, period_of(cfg.clock_select)};
    tsum    = {1'b0, tacc_r} + TSUM_W'(cycles);
    t1      = tsum;
    tb1     = tbyte_r;
    irq_nxt = 1'b0;
    if (tsum >= tper) begin
      t1  = tsum - tper;
      tb1 = tbyte_r + 8'd1;
      if (tb1 == 8'd0) begin
        tb1     = cfg.reload_value;
        irq_nxt = 1'b1;
      end
    end
    t2  = t1;
    tb2 = tb1;
    if (t1 >= tper) begin
      t2  = t1 - tper;
      tb2 = tb1 + 8'd1;
      if (tb2 == 8'd0) begin
        tb2     = cfg.reload_value;
        irq_nxt = 1'b1;
      end
    end
    if (!cfg.timer_enable) begin
      irq_nxt = 1'b0;
    end
    if (step_en && cfg.timer_enable) begin
      tacc_nxt  = t2[TACC_W-1:0];
      tbyte_nxt = tb2;
    end else begin
      tacc_nxt  = tacc_r;
      tbyte_nxt = tbyte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dacc_r  <= '0;
      dbyte_r <= DIV_BYTE_RST;
      tacc_r  <= '0;
      tbyte_r <= '0;
    end else begin
      dacc_r  <= dacc_nxt;
      dbyte_r <= dbyte_nxt;
      tacc_r  <= tacc_nxt;
      tbyte_r <= tbyte_nxt;
    end
  end

  assign res.divider_value = dbyte_nxt;
  assign res.counter_value = tbyte_nxt;
  assign res.overflow_irq  = irq_nxt;

  `DRT_ASSERT(a_irq_reload, (step_en && irq_nxt) |-> (tbyte_nxt == cfg.reload_value || tbyte_nxt == cfg.reload_value + 8'd1), "overflow without reload")
  `DRT_ASSERT(a_div_hold, !step_en |=> ($stable(dbyte_r) && $stable(dacc_r)), "divider moved without a beat")
  `DRT_ASSERT(a_tmr_frozen, (step_en && !cfg.timer_enable) |=> ($stable(tbyte_r) && $stable(tacc_r)), "disabled timer advanced")

endmodule

/* rtl/divider_and_reload_timer_top.sv */
// Divider and reload timer: takes one elapsed-cycle beat per clock while in_stall is
// low and returns one result beat (divider byte, counter byte, overflow pulse) per input
// beat. A beat passes an input register, then the update logic feeding the result
// register; throughput is one beat per cycle when out_stall is low, set by the
// combinational add/compare/subtract chain on the divider and timer accumulators. Registers
// (timer_enable, clock_select, reload_value) sit on an APB-style port at byte
// addresses 0, 4 and 8, and are meant to be written while no beat is in flight.
// Depends on drt_pkg, drt_cfg and drt_core.
`include "divider_and_reload_timer_top_assert.svh"

module divider_and_reload_timer_top #(
  parameter int DIV_PERIOD  = drt_pkg::DIV_PERIOD_DEF,
  parameter int MAX_ELAPSED = drt_pkg::MAX_ELAPSED_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [drt_pkg::CYC_W-1:0]   in_elapsed_cycles,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [drt_pkg::BYTE_W-1:0]  out_divider_value,
  output logic [drt_pkg::BYTE_W-1:0]  out_counter_value,
  output logic                        out_overflow_irq,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drt_pkg::APB_AW-1:0]  paddr,
  input  logic [drt_pkg::APB_DW-1:0]  pwdata,
  output logic [drt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import drt_pkg::*;

  localparam logic [CYC_W-1:0] MAX_CYC = CYC_W'(MAX_ELAPSED);

  cfg_t             cfg;
  res_t             res;
  logic             in_fire, adv;
  logic             s1_valid_r, s1_valid_nxt;
  logic [CYC_W-1:0] s1_cycles_r, cyc_sat;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  drt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drt_core #(
    .DIV_PERIOD  (DIV_PERIOD),
    .MAX_ELAPSED (MAX_ELAPSED)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .cycles  (s1_cycles_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Stage 1 moves into the result register when that slot is free or draining.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;
  assign cyc_sat  = (in_elapsed_cycles > MAX_CYC) ? MAX_CYC : in_elapsed_cycles;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cycles_r <= cyc_sat;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_divider_value = out_res_r.divider_value;
  assign out_counter_value = out_res_r.counter_value;
  assign out_overflow_irq  = out_res_r.overflow_irq;

  `DRT_ASSERT(a_s1_moves, (s1_valid_r && !in_stall) |=> out_valid_r, "staged beat lost")
  `DRT_ASSERT(a_out_source, $rose(out_valid_r) |-> $past(s1_valid_r), "result without a staged beat")
  `DRT_ASSERT(a_no_repeat, (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r, "result repeated")

endmodule

/* test/tb.sv */
// Testbench for divider_and_reload_timer_top: directed table then random phases,
// every result beat checked against a table value or a cycle-count predictor of the divider and timer.
// Depends on drt_pkg and the RTL under rtl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 1225;
  localparam int MAX_REPORTS    = 10;

  // timer period select codes
  localparam logic [CSEL_W-1:0] SEL_1024 = 2'd0;
  localparam logic [CSEL_W-1:0] SEL_16   = 2'd1;
  localparam logic [CSEL_W-1:0] SEL_64   = 2'd2;
  localparam logic [CSEL_W-1:0] SEL_256  = 2'd3;

  // index past the register map; writes there must be ignored
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam logic [1:0] IDX_NONE     = 2'd0;

  typedef enum logic [1:0] {ROW_BEAT, ROW_BEAT_KNOWN, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        idx;
    logic [31:0]       data;
    logic [BYTE_W-1:0] div;
    logic [BYTE_W-1:0] cnt;
    logic              irq;
  } plan_row_t;

  localparam int PLAN_ROWS = 36;

  plan_row_t plan [PLAN_ROWS] = '{
    // reset settings: timer off, divider starts at its reset byte
    '{ROW_BEAT_KNOWN, IDX_NONE, 32'd0,  8'hAB, 8'h00, 1'b0},
    '{ROW_BEAT_KNOWN, IDX_NONE, 32'd31, 8'hAB, 8'h00, 1'b0},  // saturates to 24
    '{ROW_BEAT_KNOWN, IDX_NONE, 32'd25, 8'hAB, 8'h00, 1'b0},
    '{ROW_BEAT,       IDX_NONE, 32'd1,  8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_TIMER_ENABLE, 32'd1,           8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_CLOCK_SELECT, 32'(SEL_16),     8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_RELOAD_VALUE, 32'hFF,          8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED,     32'hFFFF_FFFF,   8'h00, 8'h00, 1'b0},
    // two periods per beat at the fastest select
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd16, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd15, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd1,  8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0,  8'h00, 8'h00, 1'b0},
    // upper data bits must be dropped
    '{ROW_WRITE, REG_CLOCK_SELECT, {30'h3FFF_FFFF, SEL_1024}, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd31, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd31, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    // shorter period with a large remainder: drains two periods per beat
    '{ROW_WRITE, REG_CLOCK_SELECT, 32'(SEL_16), 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_TIMER_ENABLE, 32'hFFFF_FFFE, 8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_RELOAD_VALUE, 32'h0,         8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_TIMER_ENABLE, 32'd1,        8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_CLOCK_SELECT, 32'(SEL_256), 8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0},
    '{ROW_WRITE, REG_CLOCK_SELECT, 32'(SEL_64),  8'h00, 8'h00, 1'b0},
    '{ROW_BEAT, IDX_NONE, 32'd24, 8'h00, 8'h00, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CYC_W-1:0]  in_elapsed_cycles = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_divider_value;
  logic [BYTE_W-1:0] out_counter_value;
  logic              out_overflow_irq;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  divider_and_reload_timer_top DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_elapsed_cycles,
    .out_valid, .out_stall, .out_divider_value, .out_counter_value, .out_overflow_irq,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and register copies
  logic [8:0]        div_accum   = '0;
  logic [BYTE_W-1:0] div_count   = DIV_BYTE_RST;
  logic [TACC_W-1:0] tick_accum  = '0;
  logic [BYTE_W-1:0] tick_count  = '0;
  logic              tmr_on      = 1'b0;
  logic [CSEL_W-1:0] tmr_sel     = SEL_1024;
  logic [BYTE_W-1:0] tmr_reload  = '0;

  res_t pending_readings [$];
  int   bad_readings = 0;
  int   quiet_cycles = 0;
  bit   timed_out = 1'b0;
  bit   feed_steady = 1'b0;
  bit   sink_steady = 1'b0;

  bit   in_seen = 1'b0;
  bit   out_seen = 1'b0;
  res_t got_reading;

  function automatic int tick_period(input logic [CSEL_W-1:0] sel);
    case (sel)
      SEL_16:  return 16;
      SEL_64:  return 64;
      SEL_256: return 256;
      default: return 1024;
    endcase
  endfunction

  // Advances divider and timer by one elapsed-cycle report; returns the new reading.
  function automatic res_t advance_timers(input logic [CYC_W-1:0] elapsed);
    int   cyc;
    int   acc;
    int   per;
    res_t r;
    r.overflow_irq = 1'b0;
    cyc = (int'(elapsed) > MAX_ELAPSED_DEF) ? MAX_ELAPSED_DEF : int'(elapsed);
    acc = int'(div_accum) + cyc;
    repeat (2) begin
      if (acc >= DIV_PERIOD_DEF) begin
        acc -= DIV_PERIOD_DEF;
        div_count = div_count + 8'd1;
      end
    end
    div_accum = acc[8:0];
    if (tmr_on) begin
      per = tick_period(tmr_sel);
      acc = int'(tick_accum) + cyc;
      repeat (2) begin
        if (acc >= per) begin
          acc -= per;
          tick_count = tick_count + 8'd1;
          if (tick_count == 8'd0) begin
            tick_count = tmr_reload;
            r.overflow_irq = 1'b1;
          end
        end
      end
      tick_accum = acc[TACC_W-1:0];
    end
    r.divider_value = div_count;
    r.counter_value = tick_count;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [CYC_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CYC_W'($urandom_range(12, 24));
    if (r < 80) return CYC_W'($urandom_range(0, 11));
    if (r < 92) return CYC_W'($urandom_range(25, 31));
    return (r < 96) ? CYC_W'(0) : CYC_W'(24);
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if ($urandom_range(0, 3) == 0) return ($urandom << w) | v;
    return v;
  endfunction

  // output side: sample at negedge, where everything is settled for the next edge
  always @(negedge clk) begin
    in_seen  = rst_n && in_valid && !in_stall;
    out_seen = rst_n && out_valid && !out_stall;
    got_reading.divider_value = out_divider_value;
    got_reading.counter_value = out_counter_value;
    got_reading.overflow_irq  = out_overflow_irq;
  end

  always @(posedge clk) begin
    res_t want;
    if (out_seen) begin
      if (pending_readings.size() == 0) begin
        bad_readings++;
        if (bad_readings <= MAX_REPORTS)
          $display("%0t: unexpected beat div=%h cnt=%h irq=%b", $realtime,
                   got_reading.divider_value, got_reading.counter_value,
                   got_reading.overflow_irq);
      end else begin
        want = pending_readings.pop_front();
        if (want.divider_value != got_reading.divider_value ||
            want.counter_value != got_reading.counter_value ||
            want.overflow_irq  != got_reading.overflow_irq) begin
          bad_readings++;
          if (bad_readings <= MAX_REPORTS)
            $display("%0t: expected div=%h cnt=%h irq=%b, got div=%h cnt=%h irq=%b",
                     $realtime, want.divider_value, want.counter_value, want.overflow_irq,
                     got_reading.divider_value, got_reading.counter_value,
                     got_reading.overflow_irq);
        end
      end
    end
    quiet_cycles = (in_seen || out_seen) ? 0 : quiet_cycles + 1;
  end

  // receiver back-pressure
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run == 0 && !sink_steady && rst_n) stall_run = pick_gap();
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(input logic [CYC_W-1:0] elapsed, input bit known,
                           input res_t known_res);
    int   gap;
    bit   taken;
    res_t pred;
    gap = feed_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_cycles <= elapsed;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (!taken) @(posedge clk);
    end
    pred = advance_timers(elapsed);
    pending_readings.push_back(known ? known_res : pred);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TIMER_ENABLE: tmr_on     = data[0];
      REG_CLOCK_SELECT: tmr_sel    = data[CSEL_W-1:0];
      REG_RELOAD_VALUE: tmr_reload = data[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reprogram();
    logic [CSEL_W-1:0] sel;
    logic [BYTE_W-1:0] rel;
    int                r;
    r = $urandom_range(0, 9);
    sel = (r < 5) ? SEL_16 : CSEL_W'($urandom_range(0, 3));
    r = $urandom_range(0, 3);
    rel = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : BYTE_W'($urandom);
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_TIMER_ENABLE, with_junk(32'($urandom_range(0, 9) < 8), 1));
    if ($urandom_range(0, 2) != 0)
      write_reg(REG_CLOCK_SELECT, with_junk(32'(sel), CSEL_W));
    if ($urandom_range(0, 2) != 0)
      write_reg(REG_RELOAD_VALUE, with_junk(32'(rel), BYTE_W));
    if ($urandom_range(0, 7) == 0)
      write_reg(REG_UNMAPPED, $urandom);
  endtask

  task automatic run_stimulus();
    res_t known;
    int   beats;
    int   phase_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        known.divider_value = plan[i].div;
        known.counter_value = plan[i].cnt;
        known.overflow_irq  = plan[i].irq;
        send_beat(plan[i].data[CYC_W-1:0], plan[i].kind == ROW_BEAT_KNOWN, known);
      end
    end

    beats = 0;
    while (beats < RANDOM_BEATS) begin
      wait_idle();
      reprogram();
      feed_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(10, 120);
      repeat (phase_len) begin
        // occasionally hold off until everything in flight has come back
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_beat(pick_elapsed(), 1'b0, known);
        beats++;
      end
    end

    in_valid <= 1'b0;
    sink_steady = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    fork
      run_stimulus();
      begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out)
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    if (!timed_out && bad_readings == 0 && pending_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
